/* src/cce_pkg.sv */
package cce_pkg;

  localparam int IDX_DEF_BITS = 24;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int STEP_BITS = 33;
  localparam int RADIUS_BITS = 48;
  localparam int ROOT_BITS = 49;
  localparam int RAD_BITS = 2 * ROOT_BITS;
  localparam int DIV_N_BITS = 96;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GRID_STEP     = 3'd0,
    CFG_INNER_RADIUS  = 3'd1,
    CFG_CUTOFF_RADIUS = 3'd2,
    CFG_COEF_A        = 3'd3,
    CFG_COEF_B        = 3'd4,
    CFG_ENERGY_SHIFT  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REGION_INNER  = 2'd0,
    REGION_SWITCH = 2'd1,
    REGION_BEYOND = 2'd2
  } region_t;

  typedef struct packed {
    region_t region;
    logic    zdiv;
  } ctx_t;

  typedef struct packed {
    ctx_t               ctx;
    logic               neg;
    logic signed [63:0] pot_sw;
  } div_side_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } pp_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // partial products of a q32 multiply
  function automatic pp_t mul_pp(input logic signed [63:0] a, input logic signed [63:0] b);
    logic [63:0] ma;
    logic [63:0] mb;
    pp_t pp;
    ma = mag64(a);
    mb = mag64(b);
    pp.neg = a[63] ^ b[63];
    pp.ll = 64'(ma[31:0]) * 64'(mb[31:0]);
    pp.lh = 64'(ma[31:0]) * 64'(mb[63:32]);
    pp.hl = 64'(ma[63:32]) * 64'(mb[31:0]);
    pp.hh = 64'(ma[63:32]) * 64'(mb[63:32]);
    return pp;
  endfunction

  // sum, drop 32 fraction bits, saturate
  function automatic logic signed [63:0] mul_fin(input pp_t pp);
    logic [127:0] m;
    logic big;
    m = {64'd0, pp.ll} + {32'd0, pp.lh, 32'd0} + {32'd0, pp.hl, 32'd0} + {pp.hh, 64'd0};
    big = |m[127:95];
    if (pp.neg) begin
      return big ? S64_MIN : -$signed(m[95:32]);
    end
    return big ? S64_MAX : $signed(m[95:32]);
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat3(input logic signed [63:0] t);
    logic signed [65:0] s;
    s = {{2{t[63]}}, t} + {t[63], t, 1'b0};
    if (s[65:63] != 3'b000 && s[65:63] != 3'b111) begin
      return s[65] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

endpackage

/* src/cce_if.sv */
interface cce_req_if import cce_pkg::*; #(parameter int INDEX_BITS = IDX_DEF_BITS);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] sq_index;
  modport source(output valid, sq_index, input ready);
  modport sink(input valid, sq_index, output ready);
endinterface

interface cce_res_if import cce_pkg::*;;
  logic               valid;
  logic               ready;
  logic signed [63:0] potential;
  logic signed [63:0] force_over_r;
  logic [1:0]         region;
  modport source(output valid, potential, force_over_r, region, input ready);
  modport sink(input valid, potential, force_over_r, region, output ready);
endinterface

/* src/cutoff_coulomb_potential_eval.sv */
// Shifted Coulomb potential with a cubic switching tail, fully pipelined: one request is
// taken every clock unless the result side stalls. Its core is the square-root pipeline
// (49 stages, one root bit each) and the divider (96 stages, one quotient bit each) that
// serves both 1/r and the switching force. A stall at the result side freezes the whole
// pipeline; the input register still fills while empty. Config registers may only be
// written while nothing is in flight.
module cutoff_coulomb_potential_eval import cce_pkg::*; #(
  parameter int INDEX_BITS = IDX_DEF_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  cce_req_if.sink                  requests,
  cce_res_if.source                results
);

  typedef struct packed {
    region_t            region;
    logic signed [63:0] pot_in;
    logic signed [63:0] frc_sw;
    logic signed [63:0] pot_sw;
    logic signed [63:0] inv;
  } tail_t;

  logic [STEP_BITS-1:0]   grid_step;
  logic [RADIUS_BITS-1:0] inner_radius;
  logic [RADIUS_BITS-1:0] cutoff_radius;
  logic signed [63:0]     coef_a;
  logic signed [63:0]     coef_b;
  logic signed [63:0]     energy_shift;

  logic en;
  logic out_v;

  logic                  v0;
  logic [INDEX_BITS-1:0] k0;
  logic                  v1;
  logic [64:0]           x1;
  logic [64:0]           x_next;
  logic                  v2;
  logic [ROOT_BITS-1:0]  r2;
  logic [ROOT_BITS-1:0]  rs2;
  logic                  v3;
  ctx_t                  ctx3;
  logic [ROOT_BITS-1:0]  dvs3;
  logic [ROOT_BITS-1:0]  r3;
  logic signed [63:0]    d3;
  logic                  v4;
  ctx_t                  ctx4;
  logic [ROOT_BITS-1:0]  dvs4;
  logic signed [63:0]    num4;
  logic signed [63:0]    pot4;
  logic                  v5;
  logic [DIV_N_BITS-1:0] n5;
  logic [ROOT_BITS-1:0]  dvs5;
  div_side_t             side5;
  logic                  v6;
  logic [63:0]           q6;
  logic                  ovf6;
  div_side_t             side6;
  logic                  v7;
  tail_t                 tail7;
  logic                  v8;
  tail_t                 tail8;
  pp_t                   pp8;
  logic                  v9;
  tail_t                 tail9;
  logic signed [63:0]    sq9;
  logic                  v10;
  tail_t                 tail10;
  pp_t                   pp10;

  logic                  in_r;
  logic                  sw_r;
  logic [ROOT_BITS-1:0]  rr;
  logic                  big6;

  logic signed [63:0]    potential;
  logic signed [63:0]    force_over_r;
  region_t               region;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_step <= '0;
      inner_radius <= '0;
      cutoff_radius <= '0;
      coef_a <= '0;
      coef_b <= '0;
      energy_shift <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_STEP:     grid_step <= cfg_data[STEP_BITS-1:0];
        CFG_INNER_RADIUS:  inner_radius <= cfg_data[RADIUS_BITS-1:0];
        CFG_CUTOFF_RADIUS: cutoff_radius <= cfg_data[RADIUS_BITS-1:0];
        CFG_COEF_A:        coef_a <= $signed(cfg_data);
        CFG_COEF_B:        coef_b <= $signed(cfg_data);
        CFG_ENERGY_SHIFT:  energy_shift <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign en = !out_v || results.ready;
  assign requests.ready = en || !v0;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v3 <= 1'b0;
      v5 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      v10 <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (en || !v0) begin
        v0 <= requests.valid;
      end
      if (en) begin
        v1 <= v0;
        v3 <= v2;
        v5 <= v4;
        v7 <= v6;
        v8 <= v7;
        v9 <= v8;
        v10 <= v9;
        out_v <= v10;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en || !v0) begin
      k0 <= requests.sq_index;
    end
  end

  // squared distance: step * index
  always_comb begin
    x_next = 65'(grid_step[31:0]) * 65'(32'(k0))
           + (grid_step[32] ? {1'b0, 32'(k0), 32'd0} : 65'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x_next;
    end
  end

  cce_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vi     (v1),
    .rad_a  ({1'b0, x1, 32'd0}),
    .rad_b  ({33'd0, grid_step, 32'd0}),
    .vo     (v2),
    .root_a (r2),
    .root_b (rs2)
  );

  // region pick and zero radius patch
  always_comb begin
    in_r = r2 < {1'b0, inner_radius};
    sw_r = r2 < {1'b0, cutoff_radius};
    rr = (r2 == '0) ? (rs2 >> 1) : r2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_r) begin
        ctx3.region <= REGION_INNER;
        dvs3 <= rr;
      end else begin
        ctx3.region <= sw_r ? REGION_SWITCH : REGION_BEYOND;
        dvs3 <= (r2 == '0) ? ROOT_BITS'(1) : r2;
      end
      ctx3.zdiv <= in_r && (rr == '0);
      r3 <= r2;
      d3 <= $signed(64'(r2)) - $signed(64'(cutoff_radius));
    end
  end

  cce_poly u_poly (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vi     (v3),
    .ctx_i  (ctx3),
    .dvs_i  (dvs3),
    .r_i    (r3),
    .d_i    (d3),
    .coef_a (coef_a),
    .coef_b (coef_b),
    .vo     (v4),
    .ctx_o  (ctx4),
    .dvs_o  (dvs4),
    .num_o  (num4),
    .pot_o  (pot4)
  );

  // dividend: 2^64 for 1/r, |num| << 32 for the switching force
  always_ff @(posedge clk) begin
    if (en) begin
      if (ctx4.region == REGION_INNER) begin
        n5 <= {31'd0, 1'b1, 64'd0};
      end else begin
        n5 <= {mag64(num4), 32'd0};
      end
      dvs5 <= dvs4;
      side5.ctx <= ctx4;
      side5.neg <= !num4[63] && (num4 != '0);
      side5.pot_sw <= pot4;
    end
  end

  cce_div u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vi     (v5),
    .num_i  (n5),
    .dvs_i  (dvs5),
    .side_i (side5),
    .vo     (v6),
    .quo_o  (q6),
    .ovf_o  (ovf6),
    .side_o (side6)
  );

  assign big6 = ovf6 || q6[63];

  always_ff @(posedge clk) begin
    if (en) begin
      tail7.region <= side6.ctx.region;
      tail7.pot_sw <= side6.pot_sw;
      if (side6.ctx.zdiv || big6) begin
        tail7.inv <= S64_MAX;
        tail7.pot_in <= ssub(S64_MAX, energy_shift);
      end else begin
        tail7.inv <= $signed(q6);
        tail7.pot_in <= ssub($signed(q6), energy_shift);
      end
      if (side6.neg) begin
        tail7.frc_sw <= big6 ? S64_MIN : $signed(-q6);
      end else begin
        tail7.frc_sw <= big6 ? S64_MAX : $signed(q6);
      end
      // inner force 1/r^3
      pp8 <= mul_pp(tail7.inv, tail7.inv);
      tail8 <= tail7;
      sq9 <= mul_fin(pp8);
      tail9 <= tail8;
      pp10 <= mul_pp(sq9, tail9.inv);
      tail10 <= tail9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      region <= tail10.region;
      unique case (tail10.region)
        REGION_INNER: begin
          potential <= tail10.pot_in;
          force_over_r <= mul_fin(pp10);
        end
        REGION_SWITCH: begin
          potential <= tail10.pot_sw;
          force_over_r <= tail10.frc_sw;
        end
        default: begin
          potential <= '0;
          force_over_r <= '0;
        end
      endcase
    end
  end

  assign results.valid = out_v;
  assign results.potential = potential;
  assign results.force_over_r = force_over_r;
  assign results.region = region;

  assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.region == REGION_BEYOND)
      |-> (results.potential == '0) && (results.force_over_r == '0))
    else $error("nonzero result beyond cutoff");

  assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.region == REGION_INNER) |-> !results.force_over_r[63])
    else $error("negative inner force");

  assert property (@(posedge clk) disable iff (rst)
    !requests.ready |-> v0 && out_v && !results.ready)
    else $error("input held off without a stall");

  assert property (@(posedge clk) $past(rst) |-> !results.valid)
    else $error("result valid right after reset");

endmodule

/* src/cce_sqrt.sv */
module cce_sqrt import cce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vi,
  input  logic [RAD_BITS-1:0]  rad_a,
  input  logic [RAD_BITS-1:0]  rad_b,
  output logic                 vo,
  output logic [ROOT_BITS-1:0] root_a,
  output logic [ROOT_BITS-1:0] root_b
);

  typedef struct packed {
    logic [RAD_BITS-1:0]  rad;
    logic [ROOT_BITS+1:0] rem;
    logic [ROOT_BITS-1:0] root;
  } sq_t;

  // one root bit per stage
  function automatic sq_t sq_step(input sq_t s);
    sq_t o;
    logic [ROOT_BITS+1:0] cur;
    logic [ROOT_BITS+1:0] trial;
    cur = {s.rem[ROOT_BITS-1:0], s.rad[RAD_BITS-1 -: 2]};
    trial = {s.root, 2'b01};
    o.rad = s.rad << 2;
    if (cur >= trial) begin
      o.rem = cur - trial;
      o.root = {s.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      o.rem = cur;
      o.root = {s.root[ROOT_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  logic sv [ROOT_BITS];
  sq_t  qa [ROOT_BITS];
  sq_t  qb [ROOT_BITS];

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_stage
    logic iv;
    sq_t  ia;
    sq_t  ib;
    if (i == 0) begin : g_first
      assign iv = vi;
      assign ia = '{rad: rad_a, rem: '0, root: '0};
      assign ib = '{rad: rad_b, rem: '0, root: '0};
    end else begin : g_next
      assign iv = sv[i-1];
      assign ia = qa[i-1];
      assign ib = qb[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i] <= 1'b0;
      end else if (en) begin
        sv[i] <= iv;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        qa[i] <= sq_step(ia);
        qb[i] <= sq_step(ib);
      end
    end
  end

  assign vo = sv[ROOT_BITS-1];
  assign root_a = qa[ROOT_BITS-1].root;
  assign root_b = qb[ROOT_BITS-1].root;

endmodule

/* src/cce_div.sv */
module cce_div import cce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vi,
  input  logic [DIV_N_BITS-1:0] num_i,
  input  logic [ROOT_BITS-1:0]  dvs_i,
  input  div_side_t             side_i,
  output logic                  vo,
  output logic [63:0]           quo_o,
  output logic                  ovf_o,
  output div_side_t             side_o
);

  typedef struct packed {
    logic [DIV_N_BITS-1:0] num;
    logic [ROOT_BITS-1:0]  dvs;
    logic [ROOT_BITS-1:0]  rem;
    logic [63:0]           quo;
    logic                  ovf;
  } dv_t;

  // one quotient bit per stage, bits above 64 fold into ovf
  function automatic dv_t dv_step(input dv_t s);
    dv_t o;
    logic [ROOT_BITS:0] t;
    logic ge;
    t = {s.rem, s.num[DIV_N_BITS-1]};
    ge = t >= {1'b0, s.dvs};
    o.num = s.num << 1;
    o.dvs = s.dvs;
    o.rem = ge ? ROOT_BITS'(t - {1'b0, s.dvs}) : t[ROOT_BITS-1:0];
    o.quo = {s.quo[62:0], ge};
    o.ovf = s.ovf | s.quo[63];
    return o;
  endfunction

  logic      sv [DIV_N_BITS];
  dv_t       qd [DIV_N_BITS];
  div_side_t qs [DIV_N_BITS];

  for (genvar i = 0; i < DIV_N_BITS; i++) begin : g_stage
    logic      iv;
    dv_t       id;
    div_side_t is;
    if (i == 0) begin : g_first
      assign iv = vi;
      assign id = '{num: num_i, dvs: dvs_i, rem: '0, quo: '0, ovf: 1'b0};
      assign is = side_i;
    end else begin : g_next
      assign iv = sv[i-1];
      assign id = qd[i-1];
      assign is = qs[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i] <= 1'b0;
      end else if (en) begin
        sv[i] <= iv;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        qd[i] <= dv_step(id);
        qs[i] <= is;
      end
    end
  end

  assign vo = sv[DIV_N_BITS-1];
  assign quo_o = qd[DIV_N_BITS-1].quo;
  assign ovf_o = qd[DIV_N_BITS-1].ovf;
  assign side_o = qs[DIV_N_BITS-1];

endmodule

/* src/cce_poly.sv */
module cce_poly import cce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vi,
  input  ctx_t                 ctx_i,
  input  logic [ROOT_BITS-1:0] dvs_i,
  input  logic [ROOT_BITS-1:0] r_i,
  input  logic signed [63:0]   d_i,
  input  logic signed [63:0]   coef_a,
  input  logic signed [63:0]   coef_b,
  output logic                 vo,
  output ctx_t                 ctx_o,
  output logic [ROOT_BITS-1:0] dvs_o,
  output logic signed [63:0]   num_o,
  output logic signed [63:0]   pot_o
);

  localparam int DEPTH = 8;

  logic                 vq [DEPTH];
  ctx_t                 cq [DEPTH];
  logic [ROOT_BITS-1:0] dq [DEPTH];

  pp_t                pp_d2;
  pp_t                pp_rb;
  logic signed [63:0] d_1;
  logic signed [63:0] d2_2;
  logic signed [63:0] rb_2;
  logic signed [63:0] d_2;
  logic signed [63:0] d2_3;
  logic signed [63:0] p_3;
  logic signed [63:0] d_3;
  pp_t                pp_d3;
  pp_t                pp_t1;
  logic signed [63:0] p_4;
  logic signed [63:0] d3_5;
  logic signed [63:0] t1_5;
  logic signed [63:0] p_5;
  pp_t                pp_t3;
  pp_t                pp_pot;
  logic signed [63:0] t1_6;
  logic signed [63:0] t3_7;
  logic signed [63:0] pot_7;
  logic signed [63:0] t2_7;
  logic signed [63:0] num_8;
  logic signed [63:0] pot_8;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        vq[i] <= 1'b0;
      end
    end else if (en) begin
      vq[0] <= vi;
      for (int i = 1; i < DEPTH; i++) begin
        vq[i] <= vq[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cq[0] <= ctx_i;
      dq[0] <= dvs_i;
      for (int i = 1; i < DEPTH; i++) begin
        cq[i] <= cq[i-1];
        dq[i] <= dq[i-1];
      end
      // d^2 and b*r
      pp_d2 <= mul_pp(d_i, d_i);
      pp_rb <= mul_pp(coef_b, $signed(64'(r_i)));
      d_1 <= d_i;
      d2_2 <= mul_fin(pp_d2);
      rb_2 <= mul_fin(pp_rb);
      d_2 <= d_1;
      // p = a + b*r
      d2_3 <= d2_2;
      p_3 <= sadd(coef_a, rb_2);
      d_3 <= d_2;
      // d^3 and d^2*p
      pp_d3 <= mul_pp(d2_3, d_3);
      pp_t1 <= mul_pp(d2_3, p_3);
      p_4 <= p_3;
      d3_5 <= mul_fin(pp_d3);
      t1_5 <= mul_fin(pp_t1);
      p_5 <= p_4;
      // d^3*b and d^3*p
      pp_t3 <= mul_pp(d3_5, coef_b);
      pp_pot <= mul_pp(d3_5, p_5);
      t1_6 <= t1_5;
      t3_7 <= mul_fin(pp_t3);
      pot_7 <= mul_fin(pp_pot);
      t2_7 <= sat3(t1_6);
      num_8 <= sadd(t2_7, t3_7);
      pot_8 <= pot_7;
    end
  end

  assign vo = vq[DEPTH-1];
  assign ctx_o = cq[DEPTH-1];
  assign dvs_o = dq[DEPTH-1];
  assign num_o = num_8;
  assign pot_o = pot_8;

endmodule
